// ----- rtl/rtc_alm_pkg.sv -----
`timescale 1ns / 1ps

package rtc_alm_pkg;

  // timing and register map
  localparam int unsigned TICKS_PER_SECOND = 1000000;
  localparam int unsigned SUB_W            = 20;
  localparam logic [7:0]  TIME_REG_ADDR    = 8'd0;
  localparam logic [7:0]  ALARM_REG_ADDR   = 8'd1;
  localparam logic [7:0]  STATUS_REG_ADDR  = 8'd2;

  // bytes needed for a full data write (pointer plus four data bytes)
  localparam logic [7:0]  FULL_WRITE_BYTES = 8'd5;
  // read buffer sizes
  localparam logic [7:0]  TIME_READ_BYTES   = 8'd4;
  localparam logic [7:0]  STATUS_READ_BYTES = 8'd1;

  // command codes
  localparam logic [1:0]  CMD_TICK  = 2'd0;
  localparam logic [1:0]  CMD_WRITE = 2'd1;
  localparam logic [1:0]  CMD_READ  = 2'd2;

  // reply codes
  localparam logic [1:0]  RPL_ACK       = 2'd0;
  localparam logic [1:0]  RPL_ADDR_NACK = 2'd1;
  localparam logic [1:0]  RPL_DATA_NACK = 2'd2;
  localparam logic [1:0]  RPL_NONE      = 2'd3;

  // read byte counts
  localparam logic [2:0]  RCNT_NONE   = 3'd0;
  localparam logic [2:0]  RCNT_STATUS = 3'd1;
  localparam logic [2:0]  RCNT_TIME   = 3'd4;

  localparam logic [15:0] REJ_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  reg_address;
    logic [7:0]  byte_count;
    logic [31:0] write_value;
  } in_t;

  typedef struct packed {
    logic [1:0]  reply_code;
    logic [2:0]  read_count;
    logic [31:0] read_data;
    logic        irq_raise;
    logic [15:0] rejected_count;
  } out_t;

endpackage

// ----- rtl/rtc_seconds_counter_with_alarm_top.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// in_       input      in_valid/in_ready   in_data  (rtc_alm_pkg::in_t)
// out_      output     out_valid/out_ready out_data (rtc_alm_pkg::out_t)
//
// one request per cycle sustained while results are not stalled
// stage one is the input register, stage two the result register; the clock
// state is updated as a request moves from stage one into stage two
// a stalled result holds stage two; stage one keeps accepting until it is full
// synchronous active-low reset clears the clock state and both valid flags

module rtc_seconds_counter_with_alarm_top
  import rtc_alm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  // pipeline registers
  logic s1_valid_r;
  in_t  s1_data_r;
  logic out_valid_r;
  out_t out_data_r;

  // clock state
  logic [31:0]      seconds_r,    seconds_nxt;
  logic [SUB_W-1:0] sub_r,        sub_nxt;
  logic             tvalid_r,     tvalid_nxt;
  logic [31:0]      alarm_r,      alarm_nxt;
  logic             pending_r,    pending_nxt;
  logic             fired_r,      fired_nxt;
  logic [7:0]       pointer_r,    pointer_nxt;
  logic [15:0]      rej_r,        rej_nxt;
  out_t             result_nxt;

  logic             s1_adv;
  logic             in_acc;
  logic [SUB_W:0]   sub_inc;
  logic             sec_wrap;
  logic [31:0]      sec_tick;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // tick arithmetic
  assign sub_inc  = {1'b0, sub_r} + {{SUB_W{1'b0}}, 1'b1};
  assign sec_wrap = sub_inc >= (SUB_W + 1)'(TICKS_PER_SECOND);
  assign sec_tick = sec_wrap ? seconds_r + 32'd1 : seconds_r;

  // per-request state update and result
  always_comb begin
    seconds_nxt = seconds_r;
    sub_nxt     = sub_r;
    tvalid_nxt  = tvalid_r;
    alarm_nxt   = alarm_r;
    pending_nxt = pending_r;
    fired_nxt   = fired_r;
    pointer_nxt = pointer_r;
    rej_nxt     = rej_r;

    result_nxt.reply_code = RPL_NONE;
    result_nxt.read_count = RCNT_NONE;
    result_nxt.read_data  = 32'd0;
    result_nxt.irq_raise  = 1'b0;

    case (s1_data_r.command)
      CMD_TICK: begin
        if (tvalid_r) begin
          sub_nxt     = sec_wrap ? '0 : sub_inc[SUB_W-1:0];
          seconds_nxt = sec_tick;
          if (pending_r && !fired_r && (sec_tick >= alarm_r)) begin
            fired_nxt            = 1'b1;
            pending_nxt          = 1'b0;
            result_nxt.irq_raise = 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        if (s1_data_r.byte_count == 8'd0) begin
          result_nxt.reply_code = RPL_ADDR_NACK;
        end else begin
          pointer_nxt           = s1_data_r.reg_address;
          result_nxt.reply_code = RPL_ACK;
          if (s1_data_r.reg_address == TIME_REG_ADDR) begin
            if (s1_data_r.byte_count >= FULL_WRITE_BYTES) begin
              seconds_nxt = s1_data_r.write_value;
              sub_nxt     = '0;
              tvalid_nxt  = 1'b1;
            end
          end else if (s1_data_r.reg_address == ALARM_REG_ADDR) begin
            if (s1_data_r.byte_count >= FULL_WRITE_BYTES) begin
              // an alarm not in the future is refused once the time is set
              if (tvalid_r && (s1_data_r.write_value <= seconds_r)) begin
                result_nxt.reply_code = RPL_DATA_NACK;
                if (rej_r != REJ_MAX) begin
                  rej_nxt = rej_r + 16'd1;
                end
              end else begin
                alarm_nxt   = s1_data_r.write_value;
                pending_nxt = 1'b1;
                fired_nxt   = 1'b0;
              end
            end
          end else if (s1_data_r.reg_address != STATUS_REG_ADDR) begin
            result_nxt.reply_code = RPL_DATA_NACK;
          end
        end
      end
      CMD_READ: begin
        if (pointer_r == TIME_REG_ADDR) begin
          if (s1_data_r.byte_count >= TIME_READ_BYTES) begin
            result_nxt.read_count = RCNT_TIME;
            result_nxt.read_data  = seconds_r;
          end
        end else if (pointer_r == STATUS_REG_ADDR) begin
          if (s1_data_r.byte_count >= STATUS_READ_BYTES) begin
            result_nxt.read_count = RCNT_STATUS;
            result_nxt.read_data  = {31'd0, fired_r};
          end
        end
      end
      default: begin
      end
    endcase

    result_nxt.rejected_count = rej_nxt;
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_acc) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (s1_adv) begin
      out_data_r <= result_nxt;
    end
  end

  // clock state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seconds_r <= '0;
      sub_r     <= '0;
      tvalid_r  <= 1'b0;
      alarm_r   <= '0;
      pending_r <= 1'b0;
      fired_r   <= 1'b0;
      pointer_r <= '0;
      rej_r     <= '0;
    end else if (s1_adv) begin
      seconds_r <= seconds_nxt;
      sub_r     <= sub_nxt;
      tvalid_r  <= tvalid_nxt;
      alarm_r   <= alarm_nxt;
      pending_r <= pending_nxt;
      fired_r   <= fired_nxt;
      pointer_r <= pointer_nxt;
      rej_r     <= rej_nxt;
    end
  end

endmodule

// ----- rtl/rtc_alm_checker.sv -----
`timescale 1ns / 1ps

module rtc_alm_checker
  import rtc_alm_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // rejection count seen on the last delivered result
  logic [15:0] last_rej_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_rej_r <= '0;
    end else if (out_valid && out_ready) begin
      last_rej_r <= out_data.rejected_count;
    end
  end

  // a stalled result stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // rejection count never goes back
  a_rej_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.rejected_count >= last_rej_r)
    else $error("rejection count decreased");

  // interrupt and read bytes only on requests with no bus reply
  a_irq_no_reply: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.irq_raise || (out_data.read_count != RCNT_NONE))
      |-> out_data.reply_code == RPL_NONE)
    else $error("interrupt or read data on a write reply");

  // read byte count is one of the legal sizes
  a_read_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.read_count == RCNT_NONE) ||
                  (out_data.read_count == RCNT_STATUS) ||
                  (out_data.read_count == RCNT_TIME))
    else $error("illegal read byte count");

endmodule

bind rtc_seconds_counter_with_alarm_top rtc_alm_checker u_rtc_alm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import rtc_alm_pkg::*;

  // command code with no function in the block
  localparam logic [1:0]  CMD_IGNORED   = 2'd3;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned HOLD_EVERY    = 500;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_REQS   = 1570;
  localparam int unsigned CALM_REQS     = 250;
  localparam int unsigned REFILL_LEVEL  = 64;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  rtc_seconds_counter_with_alarm_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // requests waiting to be sent and results still owed by the block
  in_t  pending_q[$];
  out_t owed_results_q[$];
  out_t due_result;

  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned planned      = 0;
  int unsigned quiet_cycles = 0;
  logic        no_idle      = 1'b0;

  // clock state as the block should hold it
  logic [31:0] now_secs   = '0;
  int unsigned now_ticks  = 0;
  logic        now_valid  = 1'b0;
  logic [31:0] alm_secs   = '0;
  logic        alm_armed  = 1'b0;
  logic        alm_fired  = 1'b0;
  logic [7:0]  reg_ptr    = '0;
  logic [15:0] rej_total  = '0;

  // seconds value last loaded by the stimulus, for aiming alarms
  logic [31:0] plan_secs  = '0;
  logic        plan_valid = 1'b0;

  // advance the clock state by one request and return the result it causes
  function automatic out_t rtc_predict(in_t req);
    out_t res;
    res = '0;
    res.reply_code = RPL_NONE;
    case (req.command)
      CMD_TICK: begin
        if (now_valid) begin
          now_ticks++;
          if (now_ticks >= TICKS_PER_SECOND) begin
            now_ticks = 0;
            now_secs  = now_secs + 32'd1;
          end
          if (alm_armed && !alm_fired && now_secs >= alm_secs) begin
            alm_fired     = 1'b1;
            alm_armed     = 1'b0;
            res.irq_raise = 1'b1;
          end
        end
      end
      CMD_WRITE: begin
        if (req.byte_count == 8'd0) begin
          res.reply_code = RPL_ADDR_NACK;
        end else begin
          reg_ptr        = req.reg_address;
          res.reply_code = RPL_ACK;
          if (req.reg_address == TIME_REG_ADDR && req.byte_count >= FULL_WRITE_BYTES) begin
            now_secs  = req.write_value;
            now_ticks = 0;
            now_valid = 1'b1;
          end else if (req.reg_address == ALARM_REG_ADDR &&
                       req.byte_count >= FULL_WRITE_BYTES) begin
            // an alarm not in the future is refused once the time is set
            if (now_valid && req.write_value <= now_secs) begin
              if (rej_total != REJ_MAX) rej_total = rej_total + 16'd1;
              res.reply_code = RPL_DATA_NACK;
            end else begin
              alm_secs  = req.write_value;
              alm_armed = 1'b1;
              alm_fired = 1'b0;
            end
          end else if (req.reg_address != TIME_REG_ADDR &&
                       req.reg_address != ALARM_REG_ADDR &&
                       req.reg_address != STATUS_REG_ADDR) begin
            res.reply_code = RPL_DATA_NACK;
          end
        end
      end
      CMD_READ: begin
        if (reg_ptr == TIME_REG_ADDR && req.byte_count >= TIME_READ_BYTES) begin
          res.read_count = RCNT_TIME;
          res.read_data  = now_secs;
        end else if (reg_ptr == STATUS_REG_ADDR && req.byte_count >= STATUS_READ_BYTES) begin
          res.read_count = RCNT_STATUS;
          res.read_data  = {31'd0, alm_fired};
        end
      end
      default: ;
    endcase
    res.rejected_count = rej_total;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("result %0d: %s", results_seen, what);
  endtask

  task automatic queue_request(logic [1:0] cmd, logic [7:0] addr, logic [7:0] cnt,
                               logic [31:0] val);
    in_t req;
    req.command     = cmd;
    req.reg_address = addr;
    req.byte_count  = cnt;
    req.write_value = val;
    pending_q.push_back(req);
    if (cmd != CMD_IGNORED) planned++;
    if (cmd == CMD_WRITE && addr == TIME_REG_ADDR && cnt >= FULL_WRITE_BYTES) begin
      plan_secs  = val;
      plan_valid = 1'b1;
    end
  endtask

  task automatic queue_tick();
    queue_request(CMD_TICK, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  $urandom);
  endtask

  function automatic logic [7:0] pick_full_bytes();
    if ($urandom_range(0, 2) == 0) return FULL_WRITE_BYTES;
    return 8'($urandom_range(5, 255));
  endfunction

  function automatic logic [7:0] pick_read_bytes();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, 5));
  endfunction

  function automatic logic [31:0] pick_past_secs();
    if (!plan_valid) return $urandom;
    if ($urandom_range(0, 3) == 0) return plan_secs;
    return $urandom_range(0, plan_secs);
  endfunction

  // mixed traffic, much of it alarm set-and-catch-up sequences, with random content
  task automatic random_traffic(int unsigned count);
    int unsigned goal;
    int unsigned pick;
    logic [31:0] base;
    logic [31:0] target;
    logic [7:0]  ptr;
    goal = planned + count;
    while (planned < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        repeat ($urandom_range(1, 6)) queue_tick();
      end else if (pick < 48) begin
        // load time, arm a near alarm, then jump the time to just before, to or past it
        base   = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                              : $urandom_range(0, 32'hFFFF_FFF0);
        target = base + $urandom_range(1, 4);
        queue_request(CMD_WRITE, TIME_REG_ADDR, pick_full_bytes(), base);
        queue_request(CMD_WRITE, ALARM_REG_ADDR, pick_full_bytes(), target);
        repeat ($urandom_range(1, 3)) queue_tick();
        queue_request(CMD_WRITE, TIME_REG_ADDR, pick_full_bytes(),
                      target - 32'd1 + $urandom_range(0, 3));
        repeat ($urandom_range(1, 3)) queue_tick();
        queue_request(CMD_WRITE, STATUS_REG_ADDR, 8'($urandom_range(1, 4)), $urandom);
        queue_request(CMD_READ, 8'($urandom_range(0, 255)), pick_read_bytes(), $urandom);
      end else if (pick < 58) begin
        queue_request(CMD_WRITE, ALARM_REG_ADDR, pick_full_bytes(), pick_past_secs());
      end else if (pick < 63) begin
        queue_request(CMD_WRITE, ALARM_REG_ADDR, pick_full_bytes(), $urandom);
      end else if (pick < 68) begin
        queue_request(CMD_WRITE, TIME_REG_ADDR, pick_full_bytes(), $urandom);
      end else if (pick < 82) begin
        // set the pointer with a short write, then read it back
        case ($urandom_range(0, 3))
          0:       ptr = TIME_REG_ADDR;
          1:       ptr = STATUS_REG_ADDR;
          2:       ptr = ALARM_REG_ADDR;
          default: ptr = 8'($urandom_range(0, 255));
        endcase
        queue_request(CMD_WRITE, ptr, 8'($urandom_range(1, 4)), $urandom);
        repeat ($urandom_range(1, 3))
          queue_request(CMD_READ, 8'($urandom_range(0, 255)), pick_read_bytes(), $urandom);
      end else if (pick < 88) begin
        queue_request(CMD_READ, 8'($urandom_range(0, 255)), pick_read_bytes(), $urandom);
      end else if (pick < 92) begin
        queue_request(CMD_WRITE, 8'($urandom_range(0, 255)), 8'd0, $urandom);
      end else if (pick < 97) begin
        queue_request(CMD_WRITE, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 255)),
                      $urandom);
      end else begin
        queue_request(CMD_IGNORED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      $urandom);
      end
    end
  endtask

  // stimulus and end of run
  initial begin
    // time not yet valid: ticks change nothing, reads see the reset seconds
    queue_request(CMD_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    queue_request(CMD_READ, 8'hFF, TIME_READ_BYTES, 32'hFFFF_FFFF);
    queue_request(CMD_READ, 8'h00, TIME_READ_BYTES - 8'd1, 32'h0);
    queue_request(CMD_WRITE, TIME_REG_ADDR, 8'd0, 32'h1234_5678);
    // alarm taken without the past check, then read of a write-only pointer
    queue_request(CMD_WRITE, ALARM_REG_ADDR, FULL_WRITE_BYTES, 32'h0);
    queue_request(CMD_READ, 8'h00, 8'hFF, 32'h0);
    queue_request(CMD_WRITE, STATUS_REG_ADDR, 8'd1, 32'hFFFF_FFFF);
    queue_request(CMD_READ, 8'h00, 8'd0, 32'h0);
    queue_request(CMD_READ, 8'h00, STATUS_READ_BYTES, 32'h0);
    queue_request(CMD_TICK, 8'h00, 8'h00, 32'h0);
    // time becomes valid: the early alarm fires on the next tick, once only
    queue_request(CMD_WRITE, TIME_REG_ADDR, FULL_WRITE_BYTES, 32'hFFFF_FFFF);
    queue_request(CMD_TICK, 8'h00, 8'h00, 32'h0);
    queue_request(CMD_TICK, 8'h00, 8'h00, 32'h0);
    queue_request(CMD_WRITE, STATUS_REG_ADDR, 8'd4, 32'h0);
    queue_request(CMD_READ, 8'h00, 8'hFF, 32'h0);
    // alarms equal to and before the time are refused, a later one is taken
    queue_request(CMD_WRITE, ALARM_REG_ADDR, FULL_WRITE_BYTES, 32'hFFFF_FFFF);
    queue_request(CMD_WRITE, ALARM_REG_ADDR, 8'hFF, 32'h0);
    queue_request(CMD_WRITE, TIME_REG_ADDR, 8'hFF, 32'h0);
    queue_request(CMD_WRITE, ALARM_REG_ADDR, 8'd6, 32'hFFFF_FFFF);
    queue_request(CMD_WRITE, STATUS_REG_ADDR, 8'd2, 32'h0);
    queue_request(CMD_READ, 8'h00, STATUS_READ_BYTES, 32'h0);
    // unmapped pointers
    queue_request(CMD_WRITE, 8'hFF, FULL_WRITE_BYTES, 32'hA5A5_5A5A);
    queue_request(CMD_WRITE, 8'd3, 8'd1, 32'h0);
    queue_request(CMD_READ, 8'h00, 8'hFF, 32'h0);
    queue_request(CMD_IGNORED, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    // short time write moves only the pointer
    queue_request(CMD_WRITE, TIME_REG_ADDR, 8'd4, 32'hDEAD_BEEF);
    queue_request(CMD_READ, 8'h00, TIME_READ_BYTES, 32'h0);

    random_traffic(RANDOM_REQS);

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // last stretch with no idling: time at the top of the range, then calm traffic
    while (pending_q.size() > REFILL_LEVEL) @(posedge clk);
    no_idle = 1'b1;
    queue_request(CMD_WRITE, TIME_REG_ADDR, FULL_WRITE_BYTES, 32'hFFFF_FFFF);
    repeat (3) queue_tick();
    queue_request(CMD_READ, 8'h00, TIME_READ_BYTES, 32'h0);

    random_traffic(CALM_REQS);

    while (pending_q.size() != 0 || in_valid || owed_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_results_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // request driver with idle bursts and idle-free stretches
  int unsigned send_gap  = 0;
  int unsigned send_calm = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) owed_results_q.push_back(rtc_predict(in_data));
      if (send_calm != 0) send_calm--;
      else if ($urandom_range(0, 199) == 0) send_calm = $urandom_range(20, 80);
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!no_idle && send_calm == 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result receiver: idle bursts, plus two long hold-offs so the block backs up
  int unsigned recv_gap   = 0;
  int unsigned recv_calm  = 0;
  int unsigned hold_left  = 0;
  int unsigned holds_done = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (recv_calm != 0) recv_calm--;
      else if ($urandom_range(0, 199) == 0) recv_calm = $urandom_range(20, 80);
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_done < 2 && results_seen >= HOLD_EVERY * (holds_done + 1)) begin
        hold_left = HOLD_CYCLES - 1;
        holds_done++;
        out_ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!no_idle && recv_calm == 0 && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // result checker against the oldest owed result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (owed_results_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
      end else begin
        due_result = owed_results_q.pop_front();
        if (out_data.reply_code !== due_result.reply_code)
          report_mismatch($sformatf("reply_code %0d, expected %0d",
                                    out_data.reply_code, due_result.reply_code));
        if (out_data.read_count !== due_result.read_count)
          report_mismatch($sformatf("read_count %0d, expected %0d",
                                    out_data.read_count, due_result.read_count));
        if (out_data.read_data !== due_result.read_data)
          report_mismatch($sformatf("read_data 0x%0h, expected 0x%0h",
                                    out_data.read_data, due_result.read_data));
        if (out_data.irq_raise !== due_result.irq_raise)
          report_mismatch($sformatf("irq_raise %0d, expected %0d",
                                    out_data.irq_raise, due_result.irq_raise));
        if (out_data.rejected_count !== due_result.rejected_count)
          report_mismatch($sformatf("rejected_count %0d, expected %0d",
                                    out_data.rejected_count, due_result.rejected_count));
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

endmodule

// ----- files.f -----
rtl/rtc_alm_pkg.sv
rtl/rtc_seconds_counter_with_alarm_top.sv
rtl/rtc_alm_checker.sv
tb/sv/testbench.sv
